/* src/aliquot_cycle_finder_core_assert.svh */
// ----------------------------------------------------------------------------
// Aliquot cycle finder assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ALIQUOT_CYCLE_FINDER_CORE_ASSERT_SVH
`define ALIQUOT_CYCLE_FINDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define ACF_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge
`define ACF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACF_ASSERT(lbl, clk, rstn, prop, msg)
`define ACF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* src/acf_pkg.sv */
// ----------------------------------------------------------------------------
// Aliquot cycle finder package
// Widths, reset values, codes and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package acf_pkg;

	localparam int NUM_BITS_DEF = 40;
	// running value and divisor sum width
	localparam int VAL_W = 64;
	// trial divisor width: i*i <= value < 2**64 keeps i at or below 2**32
	localparam int DIV_W = 33;
	localparam int CNT_W = $clog2(VAL_W + 1);
	localparam int STEP_W = 8;
	localparam int LEN_W = 8;
	localparam int STAT_W = 2;
	localparam int REG_IDX_W = 1;

	localparam logic [STEP_W-1:0] MAX_STEPS_RST = 8'd61;
	localparam logic [VAL_W-1:0] OVF_LIMIT_RST = 64'd10000000003;

	typedef enum logic [STAT_W-1:0] {
		STATUS_NO_CYCLE = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_CYCLE    = 2'd2
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MAX_STEPS      = 1'b0,
		REG_OVERFLOW_LIMIT = 1'b1
	} reg_idx_t;

	// divider result
	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_res_t;

	// divisor-sum result
	typedef struct packed {
		logic             done;
		logic             sat;
		logic [VAL_W-1:0] sum;
	} ds_res_t;

endpackage

`default_nettype wire

/* src/acf_divider.sv */
// ----------------------------------------------------------------------------
// Aliquot cycle finder divider
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aliquot_cycle_finder_core_assert.svh"

module acf_divider (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [acf_pkg::VAL_W-1:0] dividend,
	input  wire logic [acf_pkg::DIV_W-1:0] divisor,
	output acf_pkg::div_res_t              res
);

	localparam int VAL_W = acf_pkg::VAL_W;
	localparam int DIV_W = acf_pkg::DIV_W;
	localparam int CNT_W = acf_pkg::CNT_W;

	logic [DIV_W-1:0] rem_q;
	logic [VAL_W-1:0] work_q;     // dividend bits out, quotient bits in
	logic [DIV_W-1:0] divisor_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           ge;

	assign trial = {rem_q, work_q[VAL_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VAL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q     <= '0;
			work_q    <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			work_q <= {work_q[VAL_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = work_q;
	assign res.rem  = rem_q;

	`ACF_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q), "divider done without run")
	`ACF_ASSERT(a_rem_below_divisor, clk, arst_n, done_q |-> (rem_q < divisor_q), "remainder too large")

endmodule

`default_nettype wire

/* src/acf_divsum.sv */
// ----------------------------------------------------------------------------
// Aliquot cycle finder divisor sum
// Proper-divisor sum by trial division over the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aliquot_cycle_finder_core_assert.svh"

module acf_divsum (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [acf_pkg::VAL_W-1:0] value,
	output acf_pkg::ds_res_t               res
);

	localparam int VAL_W = acf_pkg::VAL_W;
	localparam int DIV_W = acf_pkg::DIV_W;

	typedef enum logic [3:0] {
		DS_IDLE  = 4'b0001,
		DS_DIV   = 4'b0010,
		DS_ADD_I = 4'b0100,
		DS_ADD_Q = 4'b1000
	} ds_state_t;

	ds_state_t         state_q;
	logic [VAL_W-1:0]  value_q;
	logic [VAL_W-1:0]  sum_q;
	logic [VAL_W-1:0]  quot_q;
	logic [DIV_W-1:0]  i_q;
	logic              div_go_q;
	logic              done_q;
	logic              sat_q;

	acf_pkg::div_res_t div_res;
	logic [VAL_W:0]    add_i;
	logic [VAL_W:0]    add_q;
	logic [VAL_W-1:0]  i_ext;

	acf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (value_q),
		.divisor  (i_q),
		.res      (div_res)
	);

	assign i_ext = VAL_W'(i_q);
	assign add_i = {1'b0, sum_q} + {1'b0, i_ext};
	assign add_q = {1'b0, sum_q} + {1'b0, quot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= DS_IDLE;
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
			case (state_q)
				DS_IDLE: begin
					if (go) begin
						div_go_q <= 1'b1;
						state_q  <= DS_DIV;
					end
				end
				DS_DIV: begin
					if (div_res.done) begin
						if (i_ext > div_res.quot) begin
							done_q  <= 1'b1;
							state_q <= DS_IDLE;
						end else if (div_res.rem == '0) begin
							state_q <= DS_ADD_I;
						end else begin
							div_go_q <= 1'b1;
						end
					end
				end
				DS_ADD_I: begin
					if (add_i[VAL_W]) begin
						done_q  <= 1'b1;
						state_q <= DS_IDLE;
					end else if (quot_q != i_ext) begin
						state_q <= DS_ADD_Q;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= DS_DIV;
					end
				end
				DS_ADD_Q: begin
					if (add_q[VAL_W]) begin
						done_q  <= 1'b1;
						state_q <= DS_IDLE;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= DS_DIV;
					end
				end
				default: state_q <= DS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DS_IDLE: begin
				if (go) begin
					value_q <= value;
					sum_q   <= VAL_W'(1);
					i_q     <= DIV_W'(2);
					sat_q   <= 1'b0;
				end
			end
			DS_DIV: begin
				if (div_res.done) begin
					quot_q <= div_res.quot;
					if (i_ext <= div_res.quot && div_res.rem != '0) begin
						i_q <= i_q + 1'b1;
					end
				end
			end
			DS_ADD_I: begin
				if (add_i[VAL_W]) begin
					sat_q <= 1'b1;
				end else begin
					sum_q <= add_i[VAL_W-1:0];
					if (quot_q == i_ext) begin
						i_q <= i_q + 1'b1;
					end
				end
			end
			DS_ADD_Q: begin
				if (add_q[VAL_W]) begin
					sat_q <= 1'b1;
				end else begin
					sum_q <= add_q[VAL_W-1:0];
					i_q   <= i_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.sat  = sat_q;
	assign res.sum  = sum_q;

	`ACF_ASSERT(a_sum_nonzero, clk, arst_n, (state_q != DS_IDLE) |-> (sum_q != '0), "divisor sum lost its unit term")

endmodule

`default_nettype wire

/* src/aliquot_cycle_finder_core.sv */
// ----------------------------------------------------------------------------
// Aliquot cycle finder core
// Follows the aliquot sequence of a start number and reports its cycle.
// ----------------------------------------------------------------------------
// A transaction starts at a rising edge with start high and busy low;
// start_number is sampled there. The block then iterates the proper-divisor
// sum up to max_steps times and raises done for exactly one cycle with
// cycle_length, search_status and is_sociable valid in that cycle and held
// until the next start is accepted; the receiver cannot hold it off, so
// capture it then. Latency is data dependent: each trial divisor i = 2, 3,
// ... up to and including the first with i*i > value costs one pass of the
// bit-serial divider, plus state DS_ADD_I when i divides and DS_ADD_Q too
// when also value / i differs from i; one sum step on value v makes
// max(floor(sqrt(v)), 1) divider passes. With max_steps zero, done follows
// in the cycle after start. The user must write registers through
// cfg_write/cfg_index/cfg_data only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aliquot_cycle_finder_core_assert.svh"

module aliquot_cycle_finder_core #(
	parameter int NUM_BITS = acf_pkg::NUM_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command channel
	input  wire logic                          start,
	input  wire logic [NUM_BITS-1:0]           start_number,
	output logic                               busy,
	// result channel
	output logic                               done,
	output logic [acf_pkg::LEN_W-1:0]          cycle_length,
	output logic [acf_pkg::STAT_W-1:0]         search_status,
	output logic                               is_sociable,
	// configuration write port
	input  wire logic                          cfg_write,
	input  wire logic [acf_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [acf_pkg::VAL_W-1:0]     cfg_data
);

	localparam int VAL_W  = acf_pkg::VAL_W;
	localparam int STEP_W = acf_pkg::STEP_W;
	localparam int LEN_W  = acf_pkg::LEN_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} top_state_t;

	top_state_t          state_q;
	logic [STEP_W-1:0]   max_steps_q;
	logic [VAL_W-1:0]    limit_q;
	logic [NUM_BITS-1:0] start_q;
	logic [VAL_W-1:0]    running_q;
	logic [STEP_W-1:0]   steps_q;     // sum steps finished so far
	logic                ds_go_q;
	logic                done_q;
	logic [LEN_W-1:0]    length_q;
	acf_pkg::status_t    status_q;
	logic                sociable_q;

	acf_pkg::ds_res_t    ds_res;
	logic [STEP_W-1:0]   steps_next;
	logic                hit;
	logic                over;
	logic                accept;

	// divisor-sum engine: one aliquot step per go pulse
	acf_divsum u_divsum (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (ds_go_q),
		.value  (running_q),
		.res    (ds_res)
	);

	assign accept     = start && (state_q == ST_IDLE);
	assign steps_next = steps_q + 1'b1;
	// recurrence is tested first; a saturated sum never counts as recurrence
	assign hit        = !ds_res.sat && (ds_res.sum == VAL_W'(start_q));
	assign over       = ds_res.sat || (ds_res.sum > limit_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q <= acf_pkg::MAX_STEPS_RST;
			limit_q     <= acf_pkg::OVF_LIMIT_RST;
		end else if (cfg_write) begin
			case (acf_pkg::reg_idx_t'(cfg_index))
				acf_pkg::REG_MAX_STEPS:      max_steps_q <= cfg_data[STEP_W-1:0];
				acf_pkg::REG_OVERFLOW_LIMIT: limit_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ds_go_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			ds_go_q <= 1'b0;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (max_steps_q == '0) begin
							done_q <= 1'b1;
						end else begin
							ds_go_q <= 1'b1;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (ds_res.done) begin
						if (hit || over || steps_next == max_steps_q) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							ds_go_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// transaction payload and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					start_q    <= start_number;
					running_q  <= VAL_W'(start_number);
					steps_q    <= '0;
					length_q   <= '0;
					status_q   <= acf_pkg::STATUS_NO_CYCLE;
					sociable_q <= 1'b0;
				end
			end
			ST_RUN: begin
				if (ds_res.done) begin
					steps_q   <= steps_next;
					running_q <= ds_res.sum;
					if (hit) begin
						length_q   <= LEN_W'(steps_next);
						status_q   <= acf_pkg::STATUS_CYCLE;
						sociable_q <= steps_next > STEP_W'(2);
					end else if (over) begin
						status_q <= acf_pkg::STATUS_OVERFLOW;
					end
				end
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign cycle_length  = length_q;
	assign search_status = status_q;
	assign is_sociable   = sociable_q;

	`ACF_ASSERT(a_cycle_has_length, clk, arst_n, (done_q && status_q == acf_pkg::STATUS_CYCLE) |-> (length_q != '0), "cycle reported with zero length")
	`ACF_ASSERT(a_sociable_needs_cycle, clk, arst_n, (done_q && sociable_q) |-> (status_q == acf_pkg::STATUS_CYCLE && length_q > LEN_W'(2)), "sociable flag without long cycle")
	`ACF_ASSERT(a_go_only_running, clk, arst_n, ds_go_q |-> (state_q == ST_RUN), "sum step launched while idle")

endmodule

`default_nettype wire
